// File: hdl/utf8d_pkg.sv
package utf8d_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned CpW    = 21;
  localparam int unsigned AccW   = 31;
  localparam int unsigned CntW   = 3;

  // result queue depth; room for two pushes is checked before each byte
  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW  = $clog2(QDepth);
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  localparam logic [CpW-1:0]   ReplCp    = 21'h00FFFD;
  localparam logic [ByteW-1:0] ContMask  = 8'h3F;
  localparam logic [ByteW-1:0] MinCont3  = 8'hA0;
  localparam logic [ByteW-1:0] MinCont4  = 8'h90;
  localparam logic [ByteW-1:0] MinCont5  = 8'h88;
  localparam logic [ByteW-1:0] MinCont6  = 8'h84;
  localparam logic [AccW-1:0]  SurrLo    = 31'h0000D800;
  localparam logic [AccW-1:0]  SurrHi    = 31'h0000DFFF;
  localparam logic [AccW-1:0]  NcharLo   = 31'h0000FDD0;
  localparam logic [AccW-1:0]  NcharHi   = 31'h0000FDEF;
  localparam logic [15:0]      NcharTail = 16'hFFFE;
  localparam logic [AccW-1:0]  MaxCp     = 31'h0010FFFF;

  // decode results of one byte: num is 0, 1 or 2; cp0 goes out first
  typedef struct packed {
    logic [1:0]     num;
    logic [CpW-1:0] cp0;
    logic [CpW-1:0] cp1;
  } res_t;

  typedef struct packed {
    logic [CpW-1:0] cp;
    logic           last;
  } entry_t;

  function automatic logic bad_value(input logic [AccW-1:0] v);
    logic bad;
    bad = 1'b0;
    if (v >= SurrLo && v <= SurrHi)   bad = 1'b1;
    if (v >= NcharLo && v <= NcharHi) bad = 1'b1;
    if (v[15:0] >= NcharTail)         bad = 1'b1;
    if (v > MaxCp)                    bad = 1'b1;
    return bad;
  endfunction

endpackage

// File: hdl/utf8d_core.sv
module utf8d_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic [utf8d_pkg::ByteW-1:0]    byte_i,
  input  logic                           fire_i,
  output utf8d_pkg::res_t                res_o
);

  logic [utf8d_pkg::AccW-1:0] accum_q, accum_d;
  logic [utf8d_pkg::CntW-1:0] exp_q, exp_d;
  logic [utf8d_pkg::CntW-1:0] seen_q, seen_d;
  logic                       valid_q, valid_d;

  logic                       cut;
  logic [utf8d_pkg::AccW-1:0] acc_e, acc_n;
  logic [utf8d_pkg::CntW-1:0] exp_e, seen_e, seen_n;
  logic                       valid_e, first, zero, overlong;
  logic                       emit_b;
  logic [utf8d_pkg::CpW-1:0]  cp_b;

  always_comb begin
    cut = (exp_q != '0) && (byte_i[7:6] != 2'b10);

    // cut-short sequence is cleared before the byte is looked at again
    acc_e   = cut ? '0 : accum_q;
    exp_e   = cut ? '0 : exp_q;
    seen_e  = cut ? '0 : seen_q;
    valid_e = cut ? 1'b1 : valid_q;

    first    = (seen_e == '0);
    zero     = (acc_e == '0);
    overlong = (exp_e == 3'd0)
            || (exp_e == 3'd1 && first && acc_e[utf8d_pkg::AccW-1:1] == '0)
            || (exp_e == 3'd2 && first && zero && byte_i < utf8d_pkg::MinCont3)
            || (exp_e == 3'd3 && first && zero && byte_i < utf8d_pkg::MinCont4)
            || (exp_e == 3'd4 && first && zero && byte_i < utf8d_pkg::MinCont5)
            || (exp_e == 3'd5 && first && zero && byte_i < utf8d_pkg::MinCont6);
    acc_n  = {acc_e[utf8d_pkg::AccW-7:0], byte_i[5:0] & utf8d_pkg::ContMask[5:0]};
    seen_n = seen_e + 3'd1;

    accum_d = acc_e;
    exp_d   = exp_e;
    seen_d  = seen_e;
    valid_d = valid_e;
    emit_b  = 1'b0;
    cp_b    = utf8d_pkg::ReplCp;

    unique case (byte_i) inside
      [8'h00:8'h7F]: begin
        emit_b = 1'b1;
        cp_b   = {13'd0, byte_i};
      end
      [8'h80:8'hBF]: begin
        if (seen_n >= exp_e) begin
          emit_b = 1'b1;
          if (valid_e && !overlong && !utf8d_pkg::bad_value(acc_n)) begin
            cp_b = acc_n[utf8d_pkg::CpW-1:0];
          end
          accum_d = '0;
          exp_d   = '0;
          seen_d  = '0;
          valid_d = 1'b1;
        end else begin
          accum_d = acc_n;
          seen_d  = seen_n;
          valid_d = valid_e && !overlong;
        end
      end
      [8'hC0:8'hDF]: begin
        accum_d = {26'd0, byte_i[4:0]};
        exp_d   = 3'd1;
        seen_d  = '0;
      end
      [8'hE0:8'hEF]: begin
        accum_d = {27'd0, byte_i[3:0]};
        exp_d   = 3'd2;
        seen_d  = '0;
      end
      [8'hF0:8'hF7]: begin
        accum_d = {28'd0, byte_i[2:0]};
        exp_d   = 3'd3;
        seen_d  = '0;
      end
      [8'hF8:8'hFB]: begin
        accum_d = {29'd0, byte_i[1:0]};
        exp_d   = 3'd4;
        seen_d  = '0;
      end
      [8'hFC:8'hFD]: begin
        accum_d = {30'd0, byte_i[0]};
        exp_d   = 3'd5;
        seen_d  = '0;
      end
      default: begin  // 0xFE, 0xFF
        emit_b  = 1'b1;
        accum_d = '0;
        exp_d   = '0;
        seen_d  = '0;
        valid_d = 1'b1;
      end
    endcase

    res_o.num = {1'b0, cut} + {1'b0, emit_b};
    res_o.cp0 = cut ? utf8d_pkg::ReplCp : cp_b;
    res_o.cp1 = cp_b;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      accum_q <= '0;
      exp_q   <= '0;
      seen_q  <= '0;
      valid_q <= 1'b1;
    end else if (fire_i) begin
      accum_q <= accum_d;
      exp_q   <= exp_d;
      seen_q  <= seen_d;
      valid_q <= valid_d;
    end
  end

endmodule

// File: hdl/utf8d_outq.sv
module utf8d_outq (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push_i,
  input  utf8d_pkg::res_t               res_i,
  output logic                          room_o,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [23:0]                   m_axis_tdata,
  output logic                          m_axis_tlast
);

  utf8d_pkg::entry_t mem_q [utf8d_pkg::QDepth];

  logic [utf8d_pkg::QPtrW-1:0] wr_q, rd_q, wr_p1;
  logic [utf8d_pkg::QCntW-1:0] cnt_q, cnt_d;
  logic [1:0]                  num;
  logic                        pop;

  assign num   = push_i ? res_i.num : 2'd0;
  assign pop   = m_axis_tvalid && m_axis_tready;
  assign wr_p1 = wr_q + 1'b1;

  // two free slots guarantee any byte fits, whatever the pop does
  assign room_o = cnt_q <= utf8d_pkg::QCntW'(utf8d_pkg::QDepth - 2);

  assign cnt_d = cnt_q + utf8d_pkg::QCntW'(num) - utf8d_pkg::QCntW'(pop);

  always_ff @(posedge clk_i) begin
    if (num != 2'd0) begin
      mem_q[wr_q] <= '{cp: res_i.cp0, last: (num == 2'd1)};
    end
    if (num == 2'd2) begin
      mem_q[wr_p1] <= '{cp: res_i.cp1, last: 1'b1};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_q + utf8d_pkg::QPtrW'(num);
      rd_q  <= rd_q + utf8d_pkg::QPtrW'(pop);
      cnt_q <= cnt_d;
    end
  end

  assign m_axis_tvalid = cnt_q != '0;
  assign m_axis_tdata  = {3'd0, mem_q[rd_q].cp};
  assign m_axis_tlast  = mem_q[rd_q].last;

endmodule

// File: hdl/utf8_validating_decoder.sv
// UTF-8 decoder with validation. Raw bytes come in on the slave stream, one
// byte per request; Unicode code points leave on the master stream. ASCII
// passes straight through, lead bytes 0xC0-0xFD open sequences of up to five
// continuation bytes, and anything malformed (overlong forms, stray
// continuations, 0xFE/0xFF, surrogates, noncharacters, values above
// 0x10FFFF) comes out as U+FFFD. A sequence cut short by a non-continuation
// byte yields U+FFFD followed by whatever that byte decodes to, so one input
// byte gives zero, one or two results; tlast marks the final result of each
// byte. Throughput is one byte per cycle as long as each byte gives at most
// one result and the receiver keeps tready high; a byte with two results
// takes one beat per result on the single-beat master port. A byte passes
// the input register, then is decoded into a four-entry result queue.
module utf8_validating_decoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  // slave stream: tdata[7:0] = in_byte
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,
  // master stream: tdata[20:0] = code_point, tdata[23:21] = 0
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,
  // last_of_run
  output logic        m_axis_tlast
);

  // input register
  logic                            in_vld_q;
  logic [utf8d_pkg::ByteW-1:0]     in_byte_q;
  logic                            room;
  logic                            consume;
  utf8d_pkg::res_t                 res;

  // a byte is decoded once the queue can take both of its possible results
  assign consume       = in_vld_q && room;
  assign s_axis_tready = !in_vld_q || consume;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte_q <= s_axis_tdata;
    end
  end

  // sequence state and per-byte decode
  utf8d_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .byte_i (in_byte_q),
    .fire_i (consume),
    .res_o  (res)
  );

  // result queue, drains one code point per beat
  utf8d_outq u_outq (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push_i        (consume),
    .res_i         (res),
    .room_o        (room),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

// File: verif/tb_utf8_validating_decoder.sv
module tb_utf8_validating_decoder;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [23:0] m_axis_tdata;
  logic        m_axis_tlast;

  utf8_validating_decoder i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  // decoder state as the testbench tracks it
  logic [utf8d_pkg::AccW-1:0] acc_bits;
  logic [utf8d_pkg::CntW-1:0] conts_needed;
  logic [utf8d_pkg::CntW-1:0] conts_seen;
  logic                       seq_ok;

  utf8d_pkg::entry_t pending_cps[$];
  int                mismatches;
  int                bytes_sent;
  bit                src_gaps;
  bit                sink_stalls;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #3000000;
    $display("RESULT: ERROR");
    $finish;
  end

  function automatic logic cp_forbidden(input logic [utf8d_pkg::AccW-1:0] v);
    return (v >= utf8d_pkg::SurrLo && v <= utf8d_pkg::SurrHi) ||
           (v >= utf8d_pkg::NcharLo && v <= utf8d_pkg::NcharHi) ||
           (v[15:1] == utf8d_pkg::NcharTail[15:1]) || (v > utf8d_pkg::MaxCp);
  endfunction

  task automatic drop_seq();
    acc_bits     = '0;
    conts_needed = '0;
    conts_seen   = '0;
    seq_ok       = 1'b1;
  endtask

  // one accepted byte -> zero, one or two expected code points
  task automatic decode_byte(input logic [7:0] b);
    logic [utf8d_pkg::CpW-1:0] cps [2];
    int                        n;
    utf8d_pkg::entry_t         ent;
    n = 0;
    // cut short: open sequence hit by a non-continuation byte
    if (conts_needed != 0 && (b < 8'h80 || b > 8'hBF)) begin
      cps[n] = utf8d_pkg::ReplCp;
      n = n + 1;
      drop_seq();
    end
    if (b <= 8'h7F) begin
      cps[n] = utf8d_pkg::CpW'(b);
      n = n + 1;
    end else if (b <= 8'hBF) begin
      if (conts_needed == 0) begin
        seq_ok = 1'b0;
      end else if (conts_seen == 0) begin
        // overlong forms, judged on the lead and the first continuation
        case (conts_needed)
          3'd1: if (acc_bits <= 1) seq_ok = 1'b0;
          3'd2: if (acc_bits == 0 && b < utf8d_pkg::MinCont3) seq_ok = 1'b0;
          3'd3: if (acc_bits == 0 && b < utf8d_pkg::MinCont4) seq_ok = 1'b0;
          3'd4: if (acc_bits == 0 && b < utf8d_pkg::MinCont5) seq_ok = 1'b0;
          3'd5: if (acc_bits == 0 && b < utf8d_pkg::MinCont6) seq_ok = 1'b0;
          default: ;
        endcase
      end
      acc_bits   = (acc_bits << 6) | utf8d_pkg::AccW'(b & utf8d_pkg::ContMask);
      conts_seen = conts_seen + 1'b1;
      if (conts_seen >= conts_needed) begin
        cps[n] = (!seq_ok || cp_forbidden(acc_bits)) ? utf8d_pkg::ReplCp :
                                                       acc_bits[utf8d_pkg::CpW-1:0];
        n = n + 1;
        drop_seq();
      end
    end else if (b <= 8'hDF) begin
      acc_bits = utf8d_pkg::AccW'(b & 8'h1F); conts_needed = 3'd1; conts_seen = '0;
    end else if (b <= 8'hEF) begin
      acc_bits = utf8d_pkg::AccW'(b & 8'h0F); conts_needed = 3'd2; conts_seen = '0;
    end else if (b <= 8'hF7) begin
      acc_bits = utf8d_pkg::AccW'(b & 8'h07); conts_needed = 3'd3; conts_seen = '0;
    end else if (b <= 8'hFB) begin
      acc_bits = utf8d_pkg::AccW'(b & 8'h03); conts_needed = 3'd4; conts_seen = '0;
    end else if (b <= 8'hFD) begin
      acc_bits = utf8d_pkg::AccW'(b & 8'h01); conts_needed = 3'd5; conts_seen = '0;
    end else begin
      cps[n] = utf8d_pkg::ReplCp;
      n = n + 1;
      drop_seq();
    end
    for (int i = 0; i < n; i++) begin
      ent.cp   = cps[i];
      ent.last = (i == n - 1);
      pending_cps.insert(pending_cps.size(), ent);
    end
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!src_gaps || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 25);
  endfunction

  // called on a clock edge; returns on the edge that takes the byte
  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    do @(posedge clk_i); while (s_axis_tready !== 1'b1);
    bytes_sent = bytes_sent + 1;
    decode_byte(b);
  endtask

  // first `keep` bytes of the nb-byte form of v (nb above the minimum is overlong)
  task automatic send_cp(input logic [utf8d_pkg::AccW-1:0] v, input int nb,
                         input int keep);
    logic [utf8d_pkg::AccW-1:0] sh;
    if (nb == 1) begin
      send_byte(v[7:0]);
    end else begin
      sh = v >> (6 * (nb - 1));
      send_byte((8'hFF << (8 - nb)) | sh[7:0]);
      for (int k = 1; k < keep; k++) begin
        sh = v >> (6 * (nb - 1 - k));
        send_byte(8'h80 | (sh[7:0] & utf8d_pkg::ContMask));
      end
    end
  endtask

  function automatic int min_len(input logic [utf8d_pkg::AccW-1:0] v);
    if (v < 'h80) return 1;
    if (v < 'h800) return 2;
    if (v < 'h10000) return 3;
    if (v < 'h200000) return 4;
    if (v < 'h4000000) return 5;
    return 6;
  endfunction

  function automatic logic [utf8d_pkg::AccW-1:0] pick_cp();
    logic [utf8d_pkg::AccW-1:0] edges [16];
    edges = '{'h0, 'h7F, 'h80, 'h7FF, 'h800, 'hD7FF, 'hE000, 'hFFFD,
              'h10000, 'h10FFFD, 'h10FFFF, 'h110000, 'h1FFFFF, 'h200000,
              'h4000000, 'h7FFFFFFF};
    case ($urandom_range(0, 10))
      0, 1: return utf8d_pkg::AccW'($urandom_range(0, 'h7F));
      2:    return utf8d_pkg::AccW'($urandom_range('h80, 'h7FF));
      3:    return utf8d_pkg::AccW'($urandom_range('h800, 'hFFFF));
      4:    return utf8d_pkg::AccW'($urandom_range('h10000, 'h10FFFF));
      5:    return utf8d_pkg::AccW'($urandom_range('hD800, 'hDFFF));
      6:    return utf8d_pkg::AccW'($urandom_range('hFDD0, 'hFDEF));
      7:    return utf8d_pkg::AccW'(($urandom_range(0, 16) << 16) | 'hFFFE |
                                    $urandom_range(0, 1));
      8:    return utf8d_pkg::AccW'($urandom_range('h110000, 'h3FFFFFF));
      9:    return utf8d_pkg::AccW'($urandom_range('h4000000, 'h7FFFFFFF));
      default: return edges[$urandom_range(0, 15)];
    endcase
  endfunction

  // receiver: with sink_stalls, mostly short stalls, now and then a long one; else always ready
  initial begin : sink_ready
    int hold;
    hold = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold > 0) begin
        hold = hold - 1;
        m_axis_tready <= 1'b0;
      end else if (!sink_stalls) begin
        m_axis_tready <= 1'b1;
      end else if ($urandom_range(0, 39) == 0) begin
        hold = $urandom_range(8, 30);
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(0, 3) != 0);
      end
    end
  end

  always @(posedge clk_i) begin : check_results
    utf8d_pkg::entry_t want;
    if (m_axis_tvalid === 1'b1 && m_axis_tready === 1'b1) begin
      if (pending_cps.size() == 0) begin
        $display("%0t: unexpected result tdata=%h tlast=%b", $time, m_axis_tdata,
                 m_axis_tlast);
        mismatches = mismatches + 1;
      end else begin
        want = pending_cps.pop_front();
        if (m_axis_tdata !== {3'b000, want.cp}) begin
          $display("%0t: code point expected %h actual %h", $time, {3'b000, want.cp},
                   m_axis_tdata);
          mismatches = mismatches + 1;
        end
        if (m_axis_tlast !== want.last) begin
          $display("%0t: tlast expected %b actual %b", $time, want.last, m_axis_tlast);
          mismatches = mismatches + 1;
        end
      end
    end
  end

  task automatic test_ascii_controls();
    send_byte(8'h00);
    send_byte(8'h7F);
  endtask

  task automatic test_stray_and_bad_bytes();
    send_byte(8'h80);
    send_byte(8'hFE);
    send_byte(8'hFF);
  endtask

  task automatic test_overlong_forms();
    send_cp('h7F, 2, 2);    // C1 BF
    send_cp('h7FF, 3, 3);   // E0 9F BF
    send_cp('hFFFD, 4, 4);  // F0 8F BF BD
  endtask

  task automatic test_forbidden_values();
    send_cp('hD800, 3, 3);   // surrogate
    send_cp('hFDD0, 3, 3);   // noncharacter block
    send_cp('h110000, 4, 4); // above the code space
  endtask

  task automatic test_cut_short();
    send_cp('hE9, 2, 1);
    send_byte(8'h41);        // two results from one byte
    send_cp('h2000, 3, 1);
    send_cp('hE9, 2, 2);     // new lead inside an open sequence
  endtask

  task automatic test_random_stream(input int n_bytes, input bit gaps, input bit stalls);
    int                         stop_at;
    int                         nb;
    int                         keep;
    logic [utf8d_pkg::AccW-1:0] v;
    src_gaps    = gaps;
    sink_stalls = stalls;
    stop_at     = bytes_sent + n_bytes;
    while (bytes_sent < stop_at) begin
      if ($urandom_range(0, 99) < 12) begin
        send_byte(8'($urandom_range(0, 255)));
      end else begin
        v  = pick_cp();
        nb = min_len(v);
        if (nb < 6 && $urandom_range(0, 7) == 0) nb = $urandom_range(nb + 1, 6);
        keep = nb;
        if (nb > 1 && $urandom_range(0, 9) == 0) keep = $urandom_range(1, nb - 1);
        send_cp(v, nb, keep);
      end
    end
  endtask

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    mismatches    = 0;
    bytes_sent    = 0;
    src_gaps      = 1'b1;
    sink_stalls   = 1'b1;
    drop_seq();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_ascii_controls();
    test_stray_and_bad_bytes();
    test_overlong_forms();
    test_forbidden_values();
    test_cut_short();
    test_random_stream(130, 1'b1, 1'b1);
    test_random_stream(130, 1'b0, 1'b0);
    test_random_stream(130, 1'b1, 1'b0);
    test_random_stream(130, 1'b0, 1'b1);
    s_axis_tvalid <= 1'b0;

    while (pending_cps.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
